// ===== rtl/tsk_pkg.sv =====
// ----------------------------------------------------------------------------
// tsk_pkg: shared constants for the topological sorter
// Node and edge store dimensions and the command codes.
// ----------------------------------------------------------------------------
package tsk_pkg;
	localparam int NODES = 64;
	localparam int EDGES = 256;
	localparam int NW = $clog2(NODES);
	localparam int EW = $clog2(EDGES);
	localparam int CW = $clog2(EDGES + 1);
	localparam int DW = $clog2(EDGES + 1);

	typedef enum logic {
		CMD_EDGE = 1'b0,
		CMD_SORT = 1'b1
	} cmd_t;
endpackage

// ===== rtl/tsk_ram.sv =====
// ----------------------------------------------------------------------------
// tsk_ram: generic single-port-write, single-port-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tsk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/topological_sort_kahn.sv =====
// An edge word stalls the input while it is appended (longer with both_ways, as
// the reverse edge needs a tail read first); a sort word counts in-degrees over the
// stored edges, seeds the queue over all NODES, then dequeues nodes and walks edges.
// Each node word leaves when the next node is dequeued, the final word once the queue is empty.
// No new input word is taken until the current one is finished; one sort at a time.
// Reset: arst_n clears control state, flags and counts; memories are never reset.
// ----------------------------------------------------------------------------
// topological_sort_kahn: Kahn topological sorter over a stored edge list
// Loads edges into per-source linked lists held in RAM, then sorts on request.
// ----------------------------------------------------------------------------
module topological_sort_kahn (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [tsk_pkg::NW-1:0] src_node,
	input  logic [tsk_pkg::NW-1:0] dst_node,
	input  logic                 both_ways,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [tsk_pkg::NW-1:0] node_id,
	output logic                 node_valid,
	output logic                 last,
	output logic                 edges_dropped
);
	import tsk_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_APP_RD, ST_APP_WR, ST_DEG_RD, ST_DEG_RD2, ST_DEG_WR,
		ST_SEED_RD, ST_SEED_CHK, ST_DEQ, ST_DEQ_WT, ST_EMIT,
		ST_EDGE_RD, ST_EDGE_WT, ST_EDGE_UPD, ST_DONE
	} state_t;

	state_t state_q;

	// edge store and per-node lists
	logic          ed_we;
	logic [EW-1:0] ed_waddr, ed_raddr;
	logic [NW-1:0] ed_wdata, ed_rdata;
	logic          en_we;
	logic [EW-1:0] en_waddr, en_raddr, en_wdata, en_rdata;
	logic          fe_we;
	logic [NW-1:0] fe_waddr, fe_raddr;
	logic [EW-1:0] fe_wdata, fe_rdata;
	logic          le_we;
	logic [NW-1:0] le_waddr, le_raddr;
	logic [EW-1:0] le_wdata, le_rdata;
	logic          rq_we;
	logic [NW-1:0] rq_waddr, rq_raddr, rq_wdata, rq_rdata;
	logic          dg_we;
	logic [NW-1:0] dg_waddr, dg_raddr;
	logic [DW-1:0] dg_wdata, dg_rdata;

	// in-degree entries read as zero until written in the current sort
	logic [NODES-1:0] deg_vld_q;
	logic [NW-1:0]    deg_addr_q;
	logic [DW-1:0]    deg_eff;
	logic [NODES-1:0] has_q, present_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;

	logic [NW-1:0] app_u_q, app_v_q;
	logic          rev_q;
	logic [CW-1:0] scan_q;
	logic [NW:0]   nscan_q;
	logic [NW:0]   head_q, tail_q;
	logic [NW-1:0] node_q, pend_q;
	logic [EW-1:0] cur_q, stop_q;
	logic          emitted_q;

	logic [NW-1:0] node_id_q;
	logic          node_valid_q, last_q, drop_q, ovalid_q;

	tsk_ram #(.WIDTH(NW), .DEPTH(EDGES)) u_edge_dest (
		.clk, .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
		.raddr(ed_raddr), .rdata(ed_rdata));
	tsk_ram #(.WIDTH(EW), .DEPTH(EDGES)) u_edge_next (
		.clk, .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
		.raddr(en_raddr), .rdata(en_rdata));
	tsk_ram #(.WIDTH(EW), .DEPTH(NODES)) u_first_edge (
		.clk, .we(fe_we), .waddr(fe_waddr), .wdata(fe_wdata),
		.raddr(fe_raddr), .rdata(fe_rdata));
	tsk_ram #(.WIDTH(EW), .DEPTH(NODES)) u_last_edge (
		.clk, .we(le_we), .waddr(le_waddr), .wdata(le_wdata),
		.raddr(le_raddr), .rdata(le_rdata));
	tsk_ram #(.WIDTH(NW), .DEPTH(NODES)) u_ready_queue (
		.clk, .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
		.raddr(rq_raddr), .rdata(rq_rdata));
	tsk_ram #(.WIDTH(DW), .DEPTH(NODES)) u_in_degree (
		.clk, .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
		.raddr(dg_raddr), .rdata(dg_rdata));

	logic in_acc, out_acc, out_free;
	logic [NW-1:0] st_u, st_v;
	logic          st_do;
	logic          full;
	logic          emit_go, out_load;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = ovalid_q && !out_stall;
	assign out_free = !ovalid_q || !out_stall;
	assign in_stall = (state_q != ST_LOAD);
	assign full     = (count_q >= CW'(EDGES));

	// the edge being appended: forward edge first, then the reverse one
	assign st_u  = app_u_q;
	assign st_v  = app_v_q;
	assign st_do = (state_q == ST_APP_WR);

	// a node word waits for the next dequeue so the final one can carry last
	assign emit_go  = (state_q == ST_EMIT) && (out_free || !emitted_q);
	assign out_load = (emit_go && emitted_q) || (state_q == ST_DONE && out_free);

	assign deg_eff = deg_vld_q[deg_addr_q] ? dg_rdata : '0;

	// memory ports
	always_comb begin
		ed_we    = st_do && !full;
		ed_waddr = count_q[EW-1:0];
		ed_wdata = st_v;
		en_we    = st_do && !full && has_q[st_u];
		en_waddr = le_rdata;
		en_wdata = count_q[EW-1:0];
		fe_we    = st_do && !full && !has_q[st_u];
		fe_waddr = st_u;
		fe_wdata = count_q[EW-1:0];
		le_we    = st_do && !full;
		le_waddr = st_u;
		le_wdata = count_q[EW-1:0];
		ed_raddr = (state_q == ST_DEG_RD) ? scan_q[EW-1:0] : cur_q;
		en_raddr = cur_q;
		fe_raddr = (state_q == ST_DEQ_WT) ? rq_rdata : node_q;
		case (state_q)
			ST_LOAD:   le_raddr = src_node;
			ST_APP_RD: le_raddr = app_u_q;
			ST_DEQ_WT: le_raddr = rq_rdata;
			default:   le_raddr = node_q;
		endcase
		dg_raddr = (state_q == ST_SEED_RD) ? nscan_q[NW-1:0] : ed_rdata;
		dg_we    = 1'b0;
		dg_waddr = deg_addr_q;
		dg_wdata = deg_eff + DW'(1);
		if (state_q == ST_DEG_WR) begin
			dg_we = 1'b1;
		end
		if (state_q == ST_EDGE_UPD && deg_eff != '0) begin
			dg_we    = 1'b1;
			dg_wdata = deg_eff - DW'(1);
		end
		rq_we    = 1'b0;
		rq_waddr = tail_q[NW-1:0];
		rq_wdata = nscan_q[NW-1:0];
		rq_raddr = head_q[NW-1:0];
		if (state_q == ST_SEED_CHK && present_q[nscan_q[NW-1:0]] && deg_eff == '0) begin
			rq_we = 1'b1;
		end
		if (state_q == ST_EDGE_UPD && deg_eff == DW'(1)) begin
			rq_we    = 1'b1;
			rq_wdata = deg_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			has_q        <= '0;
			present_q    <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			deg_vld_q    <= '0;
			deg_addr_q   <= '0;
			app_u_q      <= '0;
			app_v_q      <= '0;
			rev_q        <= 1'b0;
			scan_q       <= '0;
			nscan_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			emitted_q    <= 1'b0;
			ovalid_q     <= 1'b0;
			node_q       <= '0;
			pend_q       <= '0;
			cur_q        <= '0;
			stop_q       <= '0;
			node_id_q    <= '0;
			node_valid_q <= 1'b0;
			last_q       <= 1'b0;
			drop_q       <= 1'b0;
		end else begin
			// hold the address of each in-degree read for the cycle its data returns
			deg_addr_q <= dg_raddr;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_acc) begin
				ovalid_q <= 1'b0;
			end
			// append edge
			if (st_do) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					has_q[st_u]     <= 1'b1;
					present_q[st_u] <= 1'b1;
					present_q[st_v] <= 1'b1;
					count_q         <= count_q + CW'(1);
				end
			end
			case (state_q)
				// the source's list tail is read on the accept cycle
				ST_LOAD: begin
					if (in_acc) begin
						if (command == CMD_SORT) begin
							scan_q    <= '0;
							nscan_q   <= '0;
							head_q    <= '0;
							tail_q    <= '0;
							emitted_q <= 1'b0;
							deg_vld_q <= '0;
							state_q   <= (count_q == '0) ? ST_SEED_RD : ST_DEG_RD;
						end else begin
							app_u_q <= src_node;
							app_v_q <= dst_node;
							rev_q   <= both_ways;
							state_q <= ST_APP_WR;
						end
					end
				end
				ST_APP_RD: state_q <= ST_APP_WR;
				ST_APP_WR: begin
					if (rev_q) begin
						app_u_q <= app_v_q;
						app_v_q <= app_u_q;
						rev_q   <= 1'b0;
						state_q <= ST_APP_RD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				// count in-degrees: read a destination, read its count, bump it
				ST_DEG_RD:  state_q <= ST_DEG_RD2;
				ST_DEG_RD2: state_q <= ST_DEG_WR;
				ST_DEG_WR: begin
					deg_vld_q[deg_addr_q] <= 1'b1;
					scan_q  <= scan_q + CW'(1);
					state_q <= (scan_q + CW'(1) == count_q) ? ST_SEED_RD : ST_DEG_RD;
				end
				// enqueue zero-in-degree present nodes in ascending order
				ST_SEED_RD: state_q <= ST_SEED_CHK;
				ST_SEED_CHK: begin
					if (rq_we) begin
						tail_q <= tail_q + 1'b1;
					end
					nscan_q <= nscan_q + 1'b1;
					state_q <= (nscan_q == (NW+1)'(NODES - 1)) ? ST_DEQ : ST_SEED_RD;
				end
				ST_DEQ: begin
					if (head_q == tail_q) begin
						state_q <= ST_DONE;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= ST_DEQ_WT;
					end
				end
				ST_DEQ_WT: begin
					node_q  <= rq_rdata;
					state_q <= ST_EMIT;
				end
				// send the previous node, keep this one pending; hold on a full output
				ST_EMIT: begin
					if (emit_go) begin
						if (emitted_q) begin
							node_id_q    <= pend_q;
							node_valid_q <= 1'b1;
							last_q       <= 1'b0;
							drop_q       <= 1'b0;
						end
						pend_q    <= node_q;
						emitted_q <= 1'b1;
						cur_q     <= fe_rdata;
						stop_q    <= le_rdata;
						state_q   <= has_q[node_q] ? ST_EDGE_RD : ST_DEQ;
					end
				end
				// walk the out-list: read edge, read successor count, lower it
				ST_EDGE_RD: state_q <= ST_EDGE_WT;
				ST_EDGE_WT: state_q <= ST_EDGE_UPD;
				ST_EDGE_UPD: begin
					if (rq_we) begin
						tail_q <= tail_q + 1'b1;
					end
					if (cur_q == stop_q) begin
						state_q <= ST_DEQ;
					end else begin
						cur_q   <= en_rdata;
						state_q <= ST_EDGE_RD;
					end
				end
				// final word: pending node or empty marker, then clear the graph
				ST_DONE: begin
					if (out_free) begin
						node_id_q    <= emitted_q ? pend_q : '0;
						node_valid_q <= emitted_q;
						last_q       <= 1'b1;
						drop_q       <= ovf_q;
						emitted_q    <= 1'b0;
						has_q        <= '0;
						present_q    <= '0;
						count_q      <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid     = ovalid_q;
	assign node_id       = node_id_q;
	assign node_valid    = node_valid_q;
	assign last          = last_q;
	assign edges_dropped = drop_q;

	// an empty-run marker is always the final word
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !node_valid_q) |-> last_q)
		else $error("invalid word without last");
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("ready queue head passed tail");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(EDGES))
		else $error("edge count beyond store");
endmodule

// ===== tb/tb_topological_sort_kahn.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_topological_sort_kahn: self-checking bench for the Kahn sorter
// Loads random and directed graphs edge by edge, sorts them, and checks every
// emitted node against an in-bench Kahn predictor, with random idling on both
// sides of the handshake.
// ----------------------------------------------------------------------------
module tb_topological_sort_kahn;
	import tsk_pkg::*;

	typedef struct packed {
		logic [NW-1:0] id;
		logic          vld;
		logic          lst;
		logic          drp;
	} node_word_t;

	class order_board;
		// graph mirror, cleared after each sort
		int          dest_of[$];
		int          src_of[$];
		bit          present[NODES];
		bit          dropped;
		node_word_t  pending[$];
		int          errors;
		int          nodes_seen;
		int          sorts_done;

		function void add_one(int u, int v);
			if (dest_of.size() >= EDGES) begin
				dropped = 1;
				return;
			end
			src_of.insert(src_of.size(), u);
			dest_of.insert(dest_of.size(), v);
			present[u] = 1;
			present[v] = 1;
		endfunction

		// note an accepted input word; a sort word yields the expected order
		function void note_word(cmd_t cmd, int u, int v, bit both);
			int indeg[NODES];
			int fifo[$];
			int n;
			int k;
			node_word_t w;
			if (cmd == CMD_EDGE) begin
				add_one(u, v);
				if (both) add_one(v, u);
				return;
			end
			sorts_done++;
			foreach (indeg[i]) indeg[i] = 0;
			foreach (dest_of[i]) indeg[dest_of[i]]++;
			for (int i = 0; i < NODES; i++)
				if (present[i] && indeg[i] == 0) fifo.insert(fifo.size(), i);
			k = 0;
			while (fifo.size() > 0) begin
				n = fifo.pop_front();
				w = '{id: NW'(n), vld: 1'b1, lst: 1'b0, drp: 1'b0};
				pending.insert(pending.size(), w);
				k++;
				// walk successors in insertion order
				foreach (src_of[i])
					if (src_of[i] == n && indeg[dest_of[i]] > 0) begin
						indeg[dest_of[i]]--;
						if (indeg[dest_of[i]] == 0) fifo.insert(fifo.size(), dest_of[i]);
					end
			end
			if (k == 0) begin
				w = '{id: '0, vld: 1'b0, lst: 1'b0, drp: 1'b0};
				pending.insert(pending.size(), w);
			end
			pending[pending.size() - 1].lst = 1'b1;
			pending[pending.size() - 1].drp = dropped;
			dest_of.delete();
			src_of.delete();
			foreach (present[i]) present[i] = 0;
			dropped = 0;
		endfunction

		function void check_word(node_word_t got);
			node_word_t exp;
			nodes_seen++;
			if (pending.size() == 0) begin
				$error("unexpected node word id=%0d", got.id);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.id !== exp.id) begin
				$error("node_id exp %0d got %0d", exp.id, got.id);
				errors++;
			end
			if (got.vld !== exp.vld) begin
				$error("node_valid exp %0d got %0d", exp.vld, got.vld);
				errors++;
			end
			if (got.lst !== exp.lst) begin
				$error("last exp %0d got %0d", exp.lst, got.lst);
				errors++;
			end
			if (got.drp !== exp.drp) begin
				$error("edges_dropped exp %0d got %0d", exp.drp, got.drp);
				errors++;
			end
		endfunction
	endclass

	localparam int LIMIT = 3_000_000;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          in_valid = 0;
	logic          in_stall;
	logic          command = 0;
	logic [NW-1:0] src_node = '0;
	logic [NW-1:0] dst_node = '0;
	logic          both_ways = 0;
	logic          out_valid;
	logic          out_stall = 0;
	logic [NW-1:0] node_id;
	logic          node_valid;
	logic          last;
	logic          edges_dropped;

	order_board board = new();
	int  cycles = 0;
	bit  calm = 0;      // set during the stretch with no idling
	int  words_sent = 0;

	topological_sort_kahn i_dut (.*);

	always #5 clk = ~clk;

	// watchdog: end the run on a hang
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// sink: stall at random, check every accepted node word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word('{id: node_id, vld: node_valid, lst: last,
				drp: edges_dropped});
		out_stall <= !calm && ($urandom_range(99) < 19);
	end

	// drive one word, holding it until accepted; idle at random first
	task automatic send_word(cmd_t cmd, int u, int v, bit both);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		src_node  <= NW'(u);
		dst_node  <= NW'(v);
		both_ways <= both;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_word(cmd, u, v, both);
		words_sent++;
	endtask

	task automatic add_edge(int u, int v, bit both = 0);
		send_word(CMD_EDGE, u, v, both);
	endtask

	task automatic sort_now();
		send_word(CMD_SORT, $urandom_range(63), $urandom_range(63), $urandom_range(1));
	endtask

	// random DAG over a random node window, plus optional cycle noise
	task automatic random_graph(int edges, bit make_cycle);
		int base;
		int span;
		int a;
		int b;
		base = $urandom_range(0, 48);
		span = $urandom_range(2, 63 - base);
		if (span > 15) span = 15;
		for (int i = 0; i < edges; i++) begin
			a = base + $urandom_range(0, span - 1);
			b = base + $urandom_range(0, span);
			if (b <= a) b = a + 1;
			if (b > 63) b = 63;
			if (make_cycle && i == edges - 1) add_edge(b, a);
			else add_edge(a, b, $urandom_range(99) < 5);
		end
		sort_now();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty sort straight after reset
		sort_now();
		// extreme indices, a chain and a duplicate edge
		add_edge(0, 63);
		add_edge(63, 62);
		add_edge(0, 63);
		add_edge(5, 0);
		sort_now();
		// self loop alone: empty run
		add_edge(7, 7);
		sort_now();
		// two-way edge: a pure cycle, plus a tail hanging off it
		add_edge(42, 21, 1);
		add_edge(21, 1);
		add_edge(3, 4);
		sort_now();
		// alternating and all-ones bit patterns in one DAG
		add_edge(6'h2A, 6'h15);
		add_edge(6'h15, 6'h3F);
		sort_now();

		// fill the store past capacity: the reverse of the last two-way edge and the edges after it are dropped
		for (int i = 0; i < 127; i++) add_edge(i % 63, 63, 1);
		add_edge(10, 20);
		add_edge(30, 40, 1);
		add_edge(50, 60);
		sort_now();

		// random graphs, with a no-idle stretch in the middle
		for (int g = 0; words_sent < 270; g++) begin
			calm = (g >= 3 && g < 9);
			random_graph($urandom_range(1, 14), $urandom_range(99) < 25);
		end
		calm = 0;

		in_valid <= 1'b0;
		while (board.pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d words in %0d sorts; checked %0d node words.",
			words_sent, board.sorts_done, board.nodes_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
